/* src/conv2d_valid_window_assert.svh */
// Assertion macros for the conv2d_valid_window block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CONV2D_VALID_WINDOW_ASSERT_SVH
`define CONV2D_VALID_WINDOW_ASSERT_SVH

// same-cycle implication
`define CV2D_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CV2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cv2d_pkg.sv */
// Shared types and constants for the conv2d_valid_window block.
// No dependencies.
package cv2d_pkg;

	// output size limit
	localparam int OUT_LIMIT = 1024;

	// item opcodes
	localparam logic ACT_COEF  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_IN_WIDTH     = 2'd0;
	localparam logic [1:0] REG_OUT_WIDTH    = 2'd1;
	localparam logic [1:0] REG_OUT_HEIGHT   = 2'd2;
	localparam logic [1:0] REG_FILTER_WIDTH = 2'd3;

	// configuration reset values
	localparam logic [10:0] RST_IN_WIDTH     = 11'd1024;
	localparam logic [10:0] RST_OUT_WIDTH    = 11'd1017;
	localparam logic [10:0] RST_OUT_HEIGHT   = 11'd1017;
	localparam logic [5:0]  RST_FILTER_WIDTH = 6'd8;

	// controller to datapath commands
	typedef struct packed {
		logic accept;   // latch the input beat
		logic kwrite;   // write the latched coefficient
		logic pix;      // write pixel, step counters, set up window
		logic issue;    // issue one tap read
		logic out_load; // move the sum into the output register
	} cv2d_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic emit;      // current pixel completes a window
		logic tap_last;  // the tap being issued is the last one
		logic pipe_busy; // reads or products still in flight
		logic out_free;  // output register can take a result
	} cv2d_sts_t;

endpackage

/* src/cv2d_ctrl.sv */
// Sequencer for the conv2d_valid_window block.
// Depends on cv2d_pkg (command and status structs, opcodes).
module cv2d_ctrl import cv2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       action,
	output logic       in_ready,
	input  cv2d_sts_t  sts,
	output cv2d_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_KWR   = 3'd1;
	localparam logic [2:0] S_PIX   = 3'd2;
	localparam logic [2:0] S_MAC   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = (action == ACT_COEF) ? S_KWR : S_PIX;
				end
			end
			S_KWR: begin
				cmd.kwrite = 1'b1;
				state_d = S_IDLE;
			end
			S_PIX: begin
				cmd.pix = 1'b1;
				state_d = sts.emit ? S_MAC : S_IDLE;
			end
			S_MAC: begin
				cmd.issue = 1'b1;
				if (sts.tap_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// wait for the last product to land and the output to free up
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/cv2d_dpath.sv */
// Datapath for the conv2d_valid_window block: config, counters, row ring,
// kernel store, shared multiply-accumulate and output register. Uses cv2d_pkg.
module cv2d_dpath import cv2d_pkg::*; #(
	parameter int MAX_FILTER = 32,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// input beat
	input  logic [9:0]  coef_index,
	input  logic [15:0] coef_value,
	input  logic [15:0] pixel,
	// output beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  out_x,
	output logic [9:0]  out_y,
	output logic [15:0] value,
	output logic        saturated,
	output logic        frame_end,
	// control
	input  cv2d_cmd_t   cmd,
	output cv2d_sts_t   sts
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int ROWW  = $clog2(OUT_LIMIT + MAX_FILTER);
	localparam int CMPW  = ((CW > ROWW) ? CW : ROWW) + 1;
	localparam int FW_W  = $clog2(MAX_FILTER + 1);
	localparam int RING  = MAX_FILTER * MAX_WIDTH;
	localparam int RAW   = $clog2(RING);
	localparam int KD    = MAX_FILTER * MAX_FILTER;
	localparam int KAW   = (KD > 1) ? $clog2(KD) : 1;
	localparam int RKW   = ((KAW + 1) > 11) ? (KAW + 1) : 11;
	localparam int KS    = 20;
	localparam int ACC_W = 32 + 2 * $clog2(MAX_FILTER);

	localparam logic [KS:0]    KM    = (KS + 1)'((2 ** KS) / KD);
	localparam logic [RKW-1:0] KDC   = RKW'(KD);
	localparam logic [RAW:0]   MWA   = (RAW + 1)'(MAX_WIDTH);
	localparam logic [RAW:0]   RINGA = (RAW + 1)'(RING);

	// ---------------- configuration registers
	logic [10:0] in_width_q, out_width_q, out_height_q;
	logic [5:0]  filter_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q     <= RST_IN_WIDTH;
			out_width_q    <= RST_OUT_WIDTH;
			out_height_q   <= RST_OUT_HEIGHT;
			filter_width_q <= RST_FILTER_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_WIDTH:     in_width_q     <= cfg_data;
				REG_OUT_WIDTH:    out_width_q    <= cfg_data;
				REG_OUT_HEIGHT:   out_height_q   <= cfg_data;
				REG_FILTER_WIDTH: filter_width_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// clamped sizes
	logic [CMPW-1:0] iw_c, ow_c, oh_c, fw_c, fwm1;

	always_comb begin
		if (in_width_q == 11'd0) begin
			iw_c = CMPW'(1);
		end else if (CMPW'(in_width_q) > CMPW'(MAX_WIDTH)) begin
			iw_c = CMPW'(MAX_WIDTH);
		end else begin
			iw_c = CMPW'(in_width_q);
		end
		ow_c = (CMPW'(out_width_q) > CMPW'(OUT_LIMIT)) ? CMPW'(OUT_LIMIT)
			: CMPW'(out_width_q);
		oh_c = (CMPW'(out_height_q) > CMPW'(OUT_LIMIT)) ? CMPW'(OUT_LIMIT)
			: CMPW'(out_height_q);
		if (filter_width_q == 6'd0) begin
			fw_c = CMPW'(1);
		end else if (CMPW'(filter_width_q) > CMPW'(MAX_FILTER)) begin
			fw_c = CMPW'(MAX_FILTER);
		end else begin
			fw_c = CMPW'(filter_width_q);
		end
		fwm1 = fw_c - CMPW'(1);
	end

	// ring offset of the window's top row: (fw-1) rows back
	logic [RAW-1:0] fwoff_q;

	always_ff @(posedge clk) begin
		fwoff_q <= RAW'((RAW + 1)'(fwm1) * MWA);
	end

	// ---------------- input beat latch
	logic [15:0]    pix_q, kval_q;
	logic [9:0]     kidx_q;
	logic [KS+10:0] kprod;
	logic [9:0]     kq_s1;

	assign kprod = (KS + 11)'(coef_index) * (KS + 11)'(KM);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q  <= pixel;
			kval_q <= coef_value;
			kidx_q <= coef_index;
			kq_s1  <= kprod[KS+9:KS];
		end
	end

	// coefficient index modulo store depth: reciprocal quotient, one correction
	logic [RKW-1:0] kqd, krem, kaddr_w;

	assign kqd     = RKW'(RKW'(kq_s1) * KDC);
	assign krem    = RKW'(kidx_q) - kqd;
	assign kaddr_w = (krem >= KDC) ? (krem - KDC) : krem;

	// ---------------- frame position
	logic [CW-1:0]   col_q;
	logic [ROWW-1:0] row_q;
	logic [RAW-1:0]  head_base_q;
	logic [CMPW-1:0] col_e, row_e, win_x, win_y, row_nx;
	logic            emit, fend, row_end, frame_done;
	logic [RAW:0]    head_nx;
	logic [RAW:0]    start_sum;
	logic [RAW-1:0]  start_base;

	always_comb begin
		col_e      = CMPW'(col_q);
		row_e      = CMPW'(row_q);
		win_x      = col_e - fwm1;
		win_y      = row_e - fwm1;
		emit       = (col_e >= fwm1) && (row_e >= fwm1) && (win_x < ow_c) && (win_y < oh_c);
		fend       = (win_x == ow_c - CMPW'(1)) && (win_y == oh_c - CMPW'(1));
		row_end    = (col_e >= iw_c - CMPW'(1));
		row_nx     = row_e + CMPW'(1);
		frame_done = (row_nx >= oh_c + fwm1);
		head_nx    = {1'b0, head_base_q} + MWA;
		if (head_nx == RINGA) begin
			head_nx = '0;
		end
		// top row of the window, wrapped around the ring
		if (head_base_q >= fwoff_q) begin
			start_sum = {1'b0, head_base_q} - {1'b0, fwoff_q};
		end else begin
			start_sum = {1'b0, head_base_q} + RINGA - {1'b0, fwoff_q};
		end
		start_base = start_sum[RAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			head_base_q <= '0;
		end else if (cmd.pix) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_done) begin
					row_q       <= '0;
					head_base_q <= '0;
				end else begin
					row_q       <= ROWW'(row_nx);
					head_base_q <= head_nx[RAW-1:0];
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- window result coordinates
	logic [CW-1:0] x_q;
	logic [9:0]    y_q;
	logic          fend_q;

	always_ff @(posedge clk) begin
		if (cmd.pix) begin
			x_q    <= CW'(win_x);
			y_q    <= 10'(win_y);
			fend_q <= fend;
		end
	end

	// ---------------- tap walk
	logic [FW_W-1:0] c_q, r_q, fwm1_t;
	logic [KAW-1:0]  kaddr_q;
	logic [RAW-1:0]  rbase_q, raddr;
	logic [RAW:0]    rbase_nx;

	assign fwm1_t       = FW_W'(fwm1);
	assign sts.tap_last = (c_q == fwm1_t) && (r_q == fwm1_t);
	assign raddr        = rbase_q + RAW'(x_q) + RAW'(c_q);

	always_comb begin
		rbase_nx = {1'b0, rbase_q} + MWA;
		if (rbase_nx == RINGA) begin
			rbase_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix) begin
			c_q     <= '0;
			r_q     <= '0;
			kaddr_q <= '0;
			rbase_q <= start_base;
		end else if (cmd.issue) begin
			kaddr_q <= kaddr_q + KAW'(1);
			if (c_q == fwm1_t) begin
				c_q     <= '0;
				r_q     <= r_q + FW_W'(1);
				rbase_q <= rbase_nx[RAW-1:0];
			end else begin
				c_q <= c_q + FW_W'(1);
			end
		end
	end

	// ---------------- row ring memory
	logic [15:0] ring_mem [RING];
	logic [15:0] rrd_s1;

	always_ff @(posedge clk) begin
		if (cmd.pix) begin
			ring_mem[head_base_q + RAW'(col_q)] <= pix_q;
		end
		if (cmd.issue) begin
			rrd_s1 <= ring_mem[raddr];
		end
	end

	// ---------------- kernel store memory
	logic [15:0] kern_mem [KD];
	logic [15:0] krd_s1;

	always_ff @(posedge clk) begin
		if (cmd.kwrite) begin
			kern_mem[kaddr_w[KAW-1:0]] <= kval_q;
		end
		if (cmd.issue) begin
			krd_s1 <= kern_mem[kaddr_q];
		end
	end

	// ---------------- multiply-accumulate pipeline
	logic             v_s1, v_s2;
	logic [31:0]      prod_s2;
	logic [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= 32'(rrd_s1) * 32'(krd_s1);
		end
		if (cmd.pix) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign sts.pipe_busy = v_s1 | v_s2;
	assign sts.emit      = emit;

	// ---------------- output register
	logic        out_valid_q;
	logic        sum_sat;
	logic [9:0]  out_x_q, out_y_q;
	logic [15:0] value_q;
	logic        sat_q, fend_out_q;

	assign sum_sat      = (acc_q > ACC_W'(33'h0_FFFF_FFFF));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q    <= 10'(x_q);
			out_y_q    <= y_q;
			value_q    <= sum_sat ? 16'hFFFF : acc_q[31:16];
			sat_q      <= sum_sat;
			fend_out_q <= fend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign value     = value_q;
	assign saturated = sat_q;
	assign frame_end = fend_out_q;

endmodule

/* src/conv2d_valid_window.sv */
// conv2d_valid_window top level (cv2d_pkg, cv2d_ctrl, cv2d_dpath): 2D valid correlation.
// A window-closing pixel is taken in S_IDLE, written in S_PIX, then its taps are issued
// in S_MAC (one tap per cycle on the shared multiplier) and drained in S_DRAIN before
// out_valid rises. No new beat is taken until that result is loaded, which waits while a
// result is held; coefficient beats and pixels that close no window take S_KWR or S_PIX.
// Reset clears counters, config (1024/1017/1017/8) and handshakes, not the stores.
`include "conv2d_valid_window_assert.svh"

module conv2d_valid_window import cv2d_pkg::*; #(
	parameter int MAX_FILTER = 32,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [9:0]  coef_index,
	input  logic [15:0] coef_value,
	input  logic [15:0] pixel,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  out_x,
	output logic [9:0]  out_y,
	output logic [15:0] value,
	output logic        saturated,
	output logic        frame_end
);

	cv2d_cmd_t cmd;
	cv2d_sts_t sts;

	// config is always taken and applies at once; write it only with no beat in flight
	assign cfg_ready = 1'b1;

	cv2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cv2d_dpath #(
		.MAX_FILTER (MAX_FILTER),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.value      (value),
		.saturated  (saturated),
		.frame_end  (frame_end),
		.cmd        (cmd),
		.sts        (sts)
	);

	// control checks
	`CV2D_ASSERT_SAME(a_issue_blocks_input, cmd.issue, !in_ready, "tap issued while ready")
	`CV2D_ASSERT_NEXT(a_last_tap_stops, cmd.issue && sts.tap_last, !cmd.issue, "tap after last")
	`CV2D_ASSERT_SAME(a_load_after_drain, cmd.out_load, !sts.pipe_busy && !cmd.issue, "early load")
	`CV2D_ASSERT_NEXT(a_plain_pixel_returns, cmd.pix && !sts.emit, in_ready, "stuck after pixel")

endmodule
